@@ design/ntc_avg_pkg.sv @@
// ----------------------------------------------------------------------------
// ntc_avg_pkg
// Shared widths, constants and the logarithm table of the averaged thermometer.
// ----------------------------------------------------------------------------
package ntc_avg_pkg;

   localparam int unsigned SupplyWidth = 13;
   localparam int unsigned OhmsWidth   = 20;
   localparam int unsigned BetaWidth   = 14;
   localparam int unsigned SampleWidth = 14;
   localparam int unsigned SumWidth    = 22;
   localparam int unsigned AvgWidth    = 15;
   localparam int unsigned ResWidth    = 32;
   localparam int unsigned TempWidth   = 18;

   localparam int unsigned CsrIdxWidth = 2;
   localparam logic [CsrIdxWidth-1:0] CSR_SUPPLY = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SERIES = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_R25    = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_BETA   = 2'd3;

   localparam logic signed [TempWidth-1:0] TempMax = 18'sd100000;
   localparam logic signed [TempWidth-1:0] TempMin = -18'sd27315;
   localparam int unsigned T0Ck    = 29815;
   localparam int unsigned ZeroCCk = 27315;
   localparam longint unsigned Ln2Q30 = 64'd744261118;

   // window total handed from accumulator to converter
   typedef struct packed {
      logic [SumWidth-1:0] sum;
   } window_type;

   function automatic logic [16:0] ln_tab(input logic [5:0] i);
      logic [16:0] v;
      case (i)
         6'd0: v = 17'd0;      6'd1: v = 17'd2017;   6'd2: v = 17'd3973;
         6'd3: v = 17'd5873;   6'd4: v = 17'd7719;   6'd5: v = 17'd9515;
         6'd6: v = 17'd11262;  6'd7: v = 17'd12965;  6'd8: v = 17'd14624;
         6'd9: v = 17'd16242;  6'd10: v = 17'd17821; 6'd11: v = 17'd19364;
         6'd12: v = 17'd20870; 6'd13: v = 17'd22343; 6'd14: v = 17'd23783;
         6'd15: v = 17'd25193; 6'd16: v = 17'd26573; 6'd17: v = 17'd27924;
         6'd18: v = 17'd29248; 6'd19: v = 17'd30546; 6'd20: v = 17'd31818;
         6'd21: v = 17'd33067; 6'd22: v = 17'd34292; 6'd23: v = 17'd35494;
         6'd24: v = 17'd36675; 6'd25: v = 17'd37835; 6'd26: v = 17'd38975;
         6'd27: v = 17'd40095; 6'd28: v = 17'd41196; 6'd29: v = 17'd42280;
         6'd30: v = 17'd43345; 6'd31: v = 17'd44394; 6'd32: v = 17'd45426;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

@@ design/ntc_avg_front.sv @@
// ----------------------------------------------------------------------------
// ntc_avg_front
// Clamp and accumulate samples; push one window total per completed window.
// ----------------------------------------------------------------------------
module ntc_avg_front #(
   parameter int unsigned SamplesPerReading = 50
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [ntc_avg_pkg::SampleWidth-1:0] sample_mv,
   input  logic                                   sample_ok,
   input  logic [ntc_avg_pkg::SupplyWidth-1:0]    supply_mv,
   output logic                                   win_valid,
   input  logic                                   win_ready,
   output ntc_avg_pkg::window_type                win_data
);
   import ntc_avg_pkg::*;

   localparam int unsigned CntWidth = 8;
   localparam logic [CntWidth-1:0] LastCount = CntWidth'(SamplesPerReading - 1);

   logic [SumWidth-1:0] sum_ff, sum_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic [SumWidth-1:0] clamped;
   logic [SumWidth-1:0] total;
   logic                accept;
   logic                last;

   always_comb begin
      if (!sample_ok || sample_mv < 0) begin
         clamped = '0;
      end else if ({1'b0, sample_mv[SampleWidth-2:0]} > {1'b0, supply_mv}) begin
         clamped = SumWidth'(supply_mv);
      end else begin
         clamped = SumWidth'(sample_mv[SampleWidth-2:0]);
      end
   end

   // last beat of a window needs room for its total downstream
   assign last     = (count_ff == LastCount);
   assign in_ready = !last || win_ready;
   assign accept   = in_valid && in_ready;
   assign total    = sum_ff + clamped;
   assign win_valid     = in_valid && last;
   assign win_data.sum  = total;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         if (last) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = total;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ design/ntc_avg_queue.sv @@
// ----------------------------------------------------------------------------
// ntc_avg_queue
// Two-entry queue of window totals between accumulator and converter.
// ----------------------------------------------------------------------------
module ntc_avg_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  ntc_avg_pkg::window_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output ntc_avg_pkg::window_type pop_data
);
   import ntc_avg_pkg::*;

   window_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in   = push ? !wr_ff : wr_ff;
      rd_in   = pop ? !rd_ff : rd_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

@@ design/ntc_avg_divider.sv @@
// ----------------------------------------------------------------------------
// ntc_avg_divider
// Restoring divider, one quotient bit a cycle, 64-bit operands.
// ----------------------------------------------------------------------------
module ntc_avg_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   assign trial    = {rem_ff, quo_ff[63]} - {1'b0, den_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

@@ design/ntc_avg_back.sv @@
// ----------------------------------------------------------------------------
// ntc_avg_back
// Sequencer that turns one window total into average, resistance and
// temperature, sharing one serial divider.
// ----------------------------------------------------------------------------
module ntc_avg_back #(
   parameter int unsigned SamplesPerReading = 50
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  win_valid,
   output logic                                  win_ready,
   input  ntc_avg_pkg::window_type               win_data,
   input  logic [ntc_avg_pkg::SupplyWidth-1:0]   supply_mv,
   input  logic [ntc_avg_pkg::OhmsWidth-1:0]     series_ohms,
   input  logic [ntc_avg_pkg::OhmsWidth-1:0]     r25_ohms,
   input  logic [ntc_avg_pkg::BetaWidth-1:0]     beta_kelvin,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [ntc_avg_pkg::AvgWidth-1:0]      avg_mv_q2,
   output logic [ntc_avg_pkg::ResWidth-1:0]      resistance_ohms,
   output logic signed [ntc_avg_pkg::TempWidth-1:0] temp_centi_c,
   output logic                                  reading_valid
);
   import ntc_avg_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_PROD  = 14'b00000000000010,
      S_AVG   = 14'b00000000000100,
      S_RES   = 14'b00000000001000,
      S_NORMA = 14'b00000000010000,
      S_NORMB = 14'b00000000100000,
      S_LNA   = 14'b00000001000000,
      S_LNB   = 14'b00000010000000,
      S_LNQ   = 14'b00000100000000,
      S_DEN   = 14'b00001000000000,
      S_NUM   = 14'b00010000000000,
      S_TEMP  = 14'b00100000000000,
      S_FIN   = 14'b01000000000000,
      S_OUT   = 14'b10000000000000
   } state_type;

   localparam logic [15:0] NCount = 16'(SamplesPerReading);
   // reciprocal of the window length, exact for any dividend below 2^25
   localparam int unsigned RecipShift = 25 + $clog2(SamplesPerReading);
   localparam logic [26:0] Recip =
      27'(((64'd1 << RecipShift) + 64'(SamplesPerReading) - 64'd1) / 64'(SamplesPerReading));
   localparam logic [63:0] BetaNumScale = 64'(T0Ck) * 64'd6553600;

   state_type   state_ff, state_in;
   logic [SumWidth-1:0] sum_ff;
   logic [28:0] full_ff;
   logic [28:0] dd_ff;
   logic [63:0] num_ff, den_ff;
   logic [5:0]  ea_ff, eb_ff;
   logic [63:0] ma_ff, mb_ff;
   logic signed [19:0] la_ff, lb_ff;
   logic signed [63:0] lnq_ff;
   logic signed [63:0] d_ff;
   logic [63:0] n_ff;
   logic [AvgWidth-1:0] avg_ff;
   logic [ResWidth-1:0] res_ff;
   logic signed [TempWidth-1:0] temp_ff;
   logic        rv_ff;

   logic        div_start;
   logic [63:0] div_a, div_b, div_q;
   logic        div_done;

   logic [24:0] avg_num;
   logic [51:0] avg_prod;

   ntc_avg_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   // leading-one search, one bit per cycle
   function automatic logic [63:0] mant_step(input logic [63:0] v);
      return {v[62:0], 1'b0};
   endfunction

   function automatic logic signed [19:0] ln_mant(input logic [63:0] m);
      logic [5:0]  i;
      logic [25:0] r;
      logic [16:0] lo, hi;
      logic [42:0] p;
      i  = {1'b0, m[62:58]};
      r  = m[57:32];
      lo = ln_tab(i);
      hi = ln_tab(i + 6'd1);
      p  = 43'(hi - lo) * 43'(r);
      return 20'(lo) + 20'(p[42:26]);
   endfunction

   logic signed [63:0] ln2_prod;
   logic signed [63:0] ln2_term;
   logic signed [63:0] ediff;
   logic signed [63:0] tk, tc;

   assign ediff    = 64'(signed'({1'b0, ea_ff})) - 64'(signed'({1'b0, eb_ff}));
   assign ln2_prod = ediff * signed'(Ln2Q30);
   // divide by 2^14 truncating toward zero
   assign ln2_term = (ln2_prod < 0) ? -((-ln2_prod) >>> 14) : (ln2_prod >>> 14);
   assign tk       = signed'(div_q);
   assign tc       = tk - 64'(ZeroCCk);

   // rounded average: (4*sum + N/2) / N by reciprocal multiplication
   assign avg_num  = {1'b0, sum_ff, 2'b00} + 25'(SamplesPerReading / 2);
   assign avg_prod = 52'(avg_num) * 52'(Recip);

   assign win_ready       = (state_ff == S_IDLE);
   assign out_valid       = (state_ff == S_OUT);
   assign avg_mv_q2       = avg_ff;
   assign resistance_ohms = res_ff;
   assign temp_centi_c    = temp_ff;
   assign reading_valid   = rv_ff;

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_a     = '0;
      div_b     = '0;
      unique case (state_ff)
         S_IDLE:  if (win_valid) state_in = S_PROD;
         S_PROD:  state_in = S_AVG;
         S_AVG:   begin
            if (sum_ff == '0 || 29'(sum_ff) >= full_ff) begin
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               div_a     = num_ff + 64'(dd_ff >> 1);
               div_b     = 64'(dd_ff);
               state_in  = S_RES;
            end
         end
         S_RES:   if (div_done) begin
            if (num_ff == '0 || den_ff == '0) state_in = S_OUT;
            else state_in = S_NORMA;
         end
         S_NORMA: if (ma_ff[63]) state_in = S_NORMB;
         S_NORMB: if (mb_ff[63]) state_in = S_LNA;
         S_LNA:   state_in = S_LNB;
         S_LNB:   state_in = S_LNQ;
         S_LNQ:   state_in = S_DEN;
         S_DEN:   state_in = S_NUM;
         S_NUM:   begin
            if (d_ff <= 0) begin
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               div_a     = n_ff + 64'(d_ff >>> 1);
               div_b     = d_ff;
               state_in  = S_TEMP;
            end
         end
         S_TEMP:  if (div_done) state_in = S_FIN;
         S_FIN:   state_in = S_OUT;
         S_OUT:   if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            sum_ff  <= win_data.sum;
            full_ff <= 29'(supply_mv) * 29'(NCount);
         end
         S_PROD: begin
            avg_ff <= avg_prod[RecipShift +: AvgWidth];
            dd_ff  <= full_ff - 29'(sum_ff);
            num_ff <= 64'(series_ohms) * 64'(sum_ff);
            res_ff <= '0;
            temp_ff <= '0;
            rv_ff  <= 1'b0;
         end
         S_AVG: begin
            den_ff <= 64'(r25_ohms) * 64'(dd_ff);
            ma_ff  <= num_ff;
            ea_ff  <= 6'd63;
         end
         S_RES: if (div_done) begin
            rv_ff  <= 1'b1;
            res_ff <= (div_q[63:32] != '0) ? '1 : div_q[31:0];
            mb_ff  <= den_ff;
            eb_ff  <= 6'd63;
            if (num_ff == '0) temp_ff <= TempMax;
            else if (den_ff == '0) temp_ff <= TempMin;
         end
         S_NORMA: if (!ma_ff[63]) begin
            ma_ff <= mant_step(ma_ff);
            ea_ff <= ea_ff - 6'd1;
         end
         S_NORMB: if (!mb_ff[63]) begin
            mb_ff <= mant_step(mb_ff);
            eb_ff <= eb_ff - 6'd1;
         end
         S_LNA: la_ff <= ln_mant(ma_ff);
         S_LNB: lb_ff <= ln_mant(mb_ff);
         S_LNQ: lnq_ff <= ln2_term + 64'(la_ff) - 64'(lb_ff);
         S_DEN: begin
            d_ff <= signed'(64'(beta_kelvin) * 64'd6553600) + lnq_ff * 64'sd29815;
            n_ff <= 64'(beta_kelvin) * BetaNumScale;
         end
         S_NUM: if (d_ff <= 0) temp_ff <= TempMax;
         S_FIN: begin
            if (tc > 64'sd100000) temp_ff <= TempMax;
            else if (tc < -64'sd27315) temp_ff <= TempMin;
            else temp_ff <= tc[TempWidth-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/ntc_averaged_temperature.sv @@
// ----------------------------------------------------------------------------
// ntc_averaged_temperature
// Averaging NTC thermistor thermometer with beta-equation conversion.
// ----------------------------------------------------------------------------
// Samples arrive as req_ beats: tdata holds sample_mv (14-bit signed),
// tuser holds sample_ok. One beat is taken per cycle while the accumulator
// runs; a bad sample adds nothing but counts toward the window.
// After SamplesPerReading beats the window total drops into a two-entry
// queue and the converter works on it while the next window accumulates.
// Conversion time per window is set by two passes of the shared serial
// divider plus the one-bit-a-cycle leading-one search of both logarithm
// operands; an invalid reading skips both. One rsp_ beat per window carries
// average, resistance, temperature (tdata) and reading_valid (tuser).
// A stalled rsp_ side holds the result; the queue then fills and the last
// beat of a window is held back until there is room.
// The csr_ port writes supply, series, R25 and beta; write only when idle.
// Reset is synchronous: window cleared, registers back to 3300 mV, 10 k,
// 10 k and 3950 K.
// ----------------------------------------------------------------------------
module ntc_averaged_temperature #(
   parameter int unsigned SamplesPerReading = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [13:0] sample_mv
   input  logic        req_tuser,   // [0] sample_ok
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [14:0] avg_mv_q2, [46:15] resistance_ohms,
                                    // [64:47] temp_centi_c
   output logic        rsp_tuser,   // [0] reading_valid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ntc_avg_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import ntc_avg_pkg::*;

   logic [SupplyWidth-1:0] supply_ff;
   logic [OhmsWidth-1:0]   series_ff, r25_ff;
   logic [BetaWidth-1:0]   beta_ff;

   logic       win_valid, win_ready, pop_valid, pop_ready;
   window_type win_data, pop_data;
   logic [AvgWidth-1:0] avg;
   logic [ResWidth-1:0] res;
   logic signed [TempWidth-1:0] temp;

   assign csr_ready = 1'b1;

   // hold configuration; write any register on a csr beat
   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= 13'd3300;
         series_ff <= 20'd10000;
         r25_ff    <= 20'd10000;
         beta_ff   <= 14'd3950;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SUPPLY: supply_ff <= csr_data[SupplyWidth-1:0];
            CSR_SERIES: series_ff <= csr_data[OhmsWidth-1:0];
            CSR_R25:    r25_ff    <= csr_data[OhmsWidth-1:0];
            CSR_BETA:   beta_ff   <= csr_data[BetaWidth-1:0];
            default: ;
         endcase
      end
   end

   ntc_avg_front #(.SamplesPerReading(SamplesPerReading)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .sample_mv (signed'(req_tdata[SampleWidth-1:0])),
      .sample_ok (req_tuser),
      .supply_mv (supply_ff),
      .win_valid (win_valid),
      .win_ready (win_ready),
      .win_data  (win_data)
   );

   ntc_avg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (win_valid),
      .push_ready (win_ready),
      .push_data  (win_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ntc_avg_back #(.SamplesPerReading(SamplesPerReading)) u_back (
      .clock           (clock),
      .reset           (reset),
      .win_valid       (pop_valid),
      .win_ready       (pop_ready),
      .win_data        (pop_data),
      .supply_mv       (supply_ff),
      .series_ohms     (series_ff),
      .r25_ohms        (r25_ff),
      .beta_kelvin     (beta_ff),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .avg_mv_q2       (avg),
      .resistance_ohms (res),
      .temp_centi_c    (temp),
      .reading_valid   (rsp_tuser)
   );

   // pack result fields, zero-fill to whole bytes
   assign rsp_tdata = {7'd0, temp, res, avg};

endmodule
